// ===== hdl/windowed_climb_rate_top_assert.svh =====
// Assertion macros for the windowed climb rate block.
// Used by windowed_climb_rate_top; expects clk and rst_n in scope.
`ifndef WINDOWED_CLIMB_RATE_TOP_ASSERT_SVH
`define WINDOWED_CLIMB_RATE_TOP_ASSERT_SVH

// same-cycle implication
`define WCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wcr_pkg.sv =====
// Shared constants, types and state encoding for the windowed climb rate block.
// No dependencies.
`timescale 1ns / 1ps
package wcr_pkg;

  localparam int HIST_DEPTH = 64;
  localparam int IDX_W      = $clog2(HIST_DEPTH);
  localparam int TIME_W     = 32;
  localparam int ALT_W      = 24;
  localparam int RATE_W     = 20;
  localparam int WIN_W      = 10;
  localparam int TFRAC_W    = 4;
  localparam int RFRAC_SH   = 8;
  localparam int ENTRY_W    = TIME_W + ALT_W;
  localparam int DIVD_W     = ALT_W + 1 + RFRAC_SH;
  localparam int DCNT_W     = $clog2(DIVD_W);

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(30);

  localparam logic [RATE_W-1:0] RATE_POS_MAX = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic [RATE_W-1:0] RATE_NEG_MAX = {1'b1, {(RATE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_DIV,
    ST_FIN
  } wcr_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/wcr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module wcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/wcr_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on wcr_pkg.
`timescale 1ns / 1ps
module wcr_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [wcr_pkg::DIVD_W-1:0]   dividend,
  input  logic [wcr_pkg::TIME_W-1:0]   divisor,
  output logic [wcr_pkg::DIVD_W-1:0]   quotient,
  output wcr_pkg::div_stat_t           stat
);

  logic                        busy_r;
  logic                        done_r;
  logic [wcr_pkg::DCNT_W-1:0]  cnt_r;
  logic [wcr_pkg::TIME_W-1:0]  rem_r;
  logic [wcr_pkg::DIVD_W-1:0]  quo_r;
  logic [wcr_pkg::TIME_W-1:0]  dsr_r;
  logic [wcr_pkg::TIME_W:0]    trial;
  logic [wcr_pkg::TIME_W:0]    diff;
  logic                        qbit;

  assign trial = {rem_r, quo_r[wcr_pkg::DIVD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign qbit  = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == wcr_pkg::DCNT_W'(wcr_pkg::DIVD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[wcr_pkg::TIME_W-1:0] : trial[wcr_pkg::TIME_W-1:0];
      quo_r <= {quo_r[wcr_pkg::DIVD_W-2:0], qbit};
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== hdl/windowed_climb_rate_top.sv =====
// Windowed climb rate: one request in, one climb rate out; history in one RAM.
// Per request: write the sample, read each history slot, then run the bit-serial divider
// only if an older sample lies in the window.
// One request at a time; ready again once the result is loaded into the output register.
// Reset (synchronous, rst_n low): valid bits cleared, window 30 s, first write to slot 0.
`timescale 1ns / 1ps
`include "windowed_climb_rate_top_assert.svh"
module windowed_climb_rate_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data,     // window_seconds
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,        // [31:0] sample_time, [55:32] sample_altitude
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,       // [19:0] climb_rate, [23:20] zero
  output logic        out_tuser        // found
);

  localparam int TW = wcr_pkg::TIME_W;
  localparam int AW = wcr_pkg::ALT_W;
  localparam int RW = wcr_pkg::RATE_W;
  localparam int IW = wcr_pkg::IDX_W;

  wcr_pkg::wcr_state_t st_r, st_nxt;

  logic [wcr_pkg::WIN_W-1:0]     win_r;
  logic [IW-1:0]                 wslot_r;
  logic [wcr_pkg::HIST_DEPTH-1:0] valid_r;
  logic [IW-1:0]                 scan_r;
  logic                          pend_r;
  logic [TW-1:0]                 now_r;
  logic signed [AW-1:0]          alt_r;
  logic [TW-1:0]                 best_t_r;
  logic signed [AW-1:0]          best_alt_r;
  logic                          found_r;
  logic                          neg_r;
  logic                          out_vld_r;
  logic [RW-1:0]                 out_rate_r;
  logic                          out_found_r;

  logic                          in_acc;
  logic                          ram_we, ram_re, div_start, out_load;
  logic [wcr_pkg::ENTRY_W-1:0]   rd_data;
  logic [TW-1:0]                 rd_t;
  logic signed [AW-1:0]          rd_alt;
  logic [TW:0]                   win_end;
  logic                          take;
  logic signed [AW:0]            dalt;
  logic [AW:0]                   dalt_mag;
  logic [TW-1:0]                 dt;
  logic [wcr_pkg::DIVD_W-1:0]    quo;
  wcr_pkg::div_stat_t            div_stat;
  logic [RW-1:0]                 rate_sat;

  assign in_tready = (st_r == wcr_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= wcr_pkg::WIN_RESET;
    end else if (cfg_wr_en) begin
      win_r <= cfg_wr_data;
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      wcr_pkg::ST_IDLE:   if (in_acc) st_nxt = wcr_pkg::ST_WRITE;
      wcr_pkg::ST_WRITE:  st_nxt = wcr_pkg::ST_SCAN;
      wcr_pkg::ST_SCAN: begin
        if (scan_r == IW'(wcr_pkg::HIST_DEPTH - 1)) st_nxt = wcr_pkg::ST_DRAIN;
      end
      wcr_pkg::ST_DRAIN:  st_nxt = wcr_pkg::ST_DECIDE;
      wcr_pkg::ST_DECIDE: st_nxt = found_r ? wcr_pkg::ST_DIV : wcr_pkg::ST_FIN;
      wcr_pkg::ST_DIV: begin
        if (div_stat.done) st_nxt = wcr_pkg::ST_FIN;
      end
      wcr_pkg::ST_FIN: begin
        if (!out_vld_r || out_tready) st_nxt = wcr_pkg::ST_IDLE;
      end
      default:            st_nxt = wcr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (st_r)
      wcr_pkg::ST_WRITE:  ram_we = 1'b1;
      wcr_pkg::ST_SCAN:   ram_re = 1'b1;
      wcr_pkg::ST_DECIDE: div_start = found_r;
      wcr_pkg::ST_FIN:    out_load = !out_vld_r || out_tready;
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= wcr_pkg::ST_IDLE;
      wslot_r <= IW'(wcr_pkg::HIST_DEPTH - 1);
      valid_r <= '0;
      scan_r  <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      pend_r <= ram_re && valid_r[scan_r];
      if (in_acc) begin
        wslot_r <= (wslot_r == IW'(wcr_pkg::HIST_DEPTH - 1)) ? '0 : wslot_r + 1'b1;
      end
      if (ram_we) begin
        valid_r[wslot_r] <= 1'b1;
        scan_r           <= '0;
        found_r          <= 1'b0;
      end
      if (ram_re) begin
        scan_r <= scan_r + 1'b1;
      end
      if (take) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r <= in_tdata[TW-1:0];
      alt_r <= in_tdata[TW+AW-1:TW];
    end
    if (ram_we) begin
      best_t_r <= now_r;
    end
    if (take) begin
      best_t_r   <= rd_t;
      best_alt_r <= rd_alt;
    end
    if (div_start) begin
      neg_r <= dalt[AW];
    end
  end

  wcr_ram #(
    .WIDTH (wcr_pkg::ENTRY_W),
    .DEPTH (wcr_pkg::HIST_DEPTH)
  ) u_hist (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wslot_r),
    .wr_data ({alt_r, now_r}),
    .rd_en   (ram_re),
    .rd_addr (scan_r),
    .rd_data (rd_data)
  );

  // oldest in-window entry; strict compare keeps the lowest slot on ties
  assign rd_t    = rd_data[TW-1:0];
  assign rd_alt  = rd_data[TW+AW-1:TW];
  assign win_end = {1'b0, rd_t} + (TW+1)'({win_r, {wcr_pkg::TFRAC_W{1'b0}}});
  assign take    = pend_r && (win_end >= {1'b0, now_r}) && (rd_t < best_t_r);

  assign dalt     = (AW+1)'(alt_r) - (AW+1)'(best_alt_r);
  assign dalt_mag = dalt[AW] ? (AW+1)'(-dalt) : dalt;
  assign dt       = now_r - best_t_r;

  wcr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({dalt_mag, {wcr_pkg::RFRAC_SH{1'b0}}}),
    .divisor  (dt),
    .quotient (quo),
    .stat     (div_stat)
  );

  always_comb begin
    if (!neg_r) begin
      rate_sat = (quo > wcr_pkg::DIVD_W'(wcr_pkg::RATE_POS_MAX)) ?
                 wcr_pkg::RATE_POS_MAX : quo[RW-1:0];
    end else begin
      rate_sat = (quo > wcr_pkg::DIVD_W'(wcr_pkg::RATE_NEG_MAX)) ?
                 wcr_pkg::RATE_NEG_MAX : RW'(-quo[RW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rate_r  <= found_r ? rate_sat : '0;
      out_found_r <= found_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0, out_rate_r};
  assign out_tuser  = out_found_r;

  `WCR_ASSERT_NEXT(a_acc_write, in_acc, st_r == wcr_pkg::ST_WRITE, "request not written")
  `WCR_ASSERT_NEXT(a_valid_set, ram_we, valid_r[$past(wslot_r)], "slot not marked valid")
  `WCR_ASSERT_NOW(a_found_older, div_start, best_t_r < now_r, "chosen sample not older")
  `WCR_ASSERT_NOW(a_div_live, st_r == wcr_pkg::ST_DIV, div_stat.busy || div_stat.done,
                  "divider idle while waited on")

endmodule

// ===== verif/windowed_climb_rate_checker.sv =====
// Checker for the windowed climb rate block: watches the request, result and
// window-write ports, predicts each climb rate and compares it. Needs wcr_pkg.
`timescale 1ns / 1ps
module windowed_climb_rate_checker
  import wcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tuser,
  output int          mismatch_count,
  output int          pending_count,
  output int          result_count,
  output int          found_count
);

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              found;
  } climb_t;

  localparam longint RateHi = (longint'(1) <<< (RATE_W - 1)) - 1;
  localparam longint RateLo = -(longint'(1) <<< (RATE_W - 1));

  logic [TIME_W-1:0]        hist_time  [HIST_DEPTH];
  logic signed [ALT_W-1:0]  hist_alt   [HIST_DEPTH];
  logic                     hist_valid [HIST_DEPTH];
  logic [IDX_W-1:0]         wr_slot;
  logic [WIN_W-1:0]         win_sec;
  climb_t                   pending_rates [$];
  climb_t                   got;
  climb_t                   want;

  function automatic climb_t predict_climb(input logic [TIME_W-1:0] now,
                                           input logic signed [ALT_W-1:0] alt);
    logic [IDX_W-1:0] best;
    logic [TIME_W:0]  win_q4;
    longint           d_alt;
    longint           d_time;
    longint           q;
    int               i;
    climb_t           r;
    begin
      wr_slot = (wr_slot == IDX_W'(HIST_DEPTH - 1)) ? '0 : wr_slot + 1'b1;
      hist_time[wr_slot]  = now;
      hist_alt[wr_slot]   = alt;
      hist_valid[wr_slot] = 1'b1;
      win_q4 = (TIME_W + 1)'({win_sec, 4'd0});
      best = wr_slot;
      for (i = 0; i < HIST_DEPTH; i++) begin
        if (hist_valid[i] && ({1'b0, hist_time[i]} + win_q4 >= {1'b0, now}) &&
            hist_time[i] < hist_time[best]) begin
          best = IDX_W'(i);
        end
      end
      r.rate  = '0;
      r.found = 1'b0;
      if (best != wr_slot) begin
        d_alt  = longint'(alt) - longint'(hist_alt[best]);
        d_time = longint'(now) - longint'(hist_time[best]);
        if (d_time > 0) begin
          q = (d_alt * 256) / d_time;
          if (q > RateHi) q = RateHi;
          if (q < RateLo) q = RateLo;
          r.rate  = q[RATE_W-1:0];
          r.found = 1'b1;
        end
      end
      return r;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (hist_valid[i]) hist_valid[i] = 1'b0;
      wr_slot = IDX_W'(HIST_DEPTH - 1);
      win_sec = WIN_RESET;
      pending_rates.delete();
      mismatch_count = 0;
      result_count = 0;
      found_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.rate  = out_tdata[RATE_W-1:0];
        got.found = out_tuser;
        result_count++;
        if (pending_rates.size() == 0) begin
          $error("climb rate result %0d with no request pending", $signed(got.rate));
          mismatch_count++;
        end else begin
          want = pending_rates.pop_front();
          if (got.rate !== want.rate) begin
            $error("climb_rate: expected %0d, got %0d",
                   $signed(want.rate), $signed(got.rate));
            mismatch_count++;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            mismatch_count++;
          end
          if (want.found) found_count++;
        end
      end
      if (cfg_wr_en) win_sec = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        pending_rates.push_back(predict_climb(in_tdata[TIME_W-1:0],
                                              in_tdata[TIME_W +: ALT_W]));
      end
    end
    pending_count = pending_rates.size();
  end

endmodule

// ===== verif/windowed_climb_rate_top_tb.sv =====
// Testbench top for windowed_climb_rate_top: clock, reset, sample requests,
// window writes and the verdict. Needs wcr_pkg and windowed_climb_rate_checker.
`timescale 1ns / 1ps
module windowed_climb_rate_top_tb;
  import wcr_pkg::*;

  localparam int NumSegments  = 8;
  localparam int SegSamples   = 210;
  localparam int HoldCycles   = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [9:0]  cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;

  int mismatch_count;
  int pending_count;
  int result_count;
  int found_count;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int n_requests = 0;
  int n_windows = 0;

  logic [TIME_W-1:0] cur_t;
  logic [ALT_W-1:0]  cur_a;
  logic [WIN_W-1:0]  win;
  int                step_max;
  int                rt;
  int                ra;

  always #6 clk = ~clk;

  windowed_climb_rate_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  windowed_climb_rate_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .result_count   (result_count),
    .found_count    (found_count)
  );

  // result side: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_served != hold_asked) begin
        out_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_served++;
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_sample(input logic [TIME_W-1:0] t, input logic [ALT_W-1:0] a);
    begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= {a, t};
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      n_requests++;
      @(negedge clk);
    end
  endtask

  task automatic set_window(input logic [WIN_W-1:0] v);
    begin
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= v;
      @(negedge clk);
      cfg_wr_en   <= 1'b0;
      n_windows++;
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 32;
    recv_idle_pct = 82;

    // directed, reset window of 30 s (480 in Q.4)
    send_sample(32'd0, 24'd0);                  // nothing older
    send_sample(32'd16, 24'h7FFFFF);            // saturates high
    send_sample(32'd32, 24'h800000);            // saturates low
    send_sample(32'd35, 24'd0);                 // zero rate, found
    send_sample(32'd48, 24'hFFFFFF);            // truncation toward zero
    send_sample(32'd1_000_000, 24'd100);        // jump, nothing in window
    send_sample(32'd1_000_000, 24'd200);        // equal time only
    send_sample(32'd1_000_003, 24'd199);        // tie: lowest slot wins
    send_sample(32'd1_000_001, 24'd0);          // time backwards, older exists
    send_sample(32'd2_000_000, 24'd0);
    send_sample(32'd1_999_900, 24'd5);          // backwards, only newer in window
    send_sample(32'd3_000_000, 24'd10);
    send_sample(32'd3_000_480, 24'd20);         // exactly on window edge
    send_sample(32'd3_000_961, 24'd30);         // one past the edge
    send_sample(32'hFFFF_FF00, 24'd0);
    send_sample(32'hFFFF_FFFF, 24'd1000);       // window sum above 32 bits
    send_sample(32'd0, 24'd0);                  // wrap to zero, nothing older
    send_sample(32'd5, 24'h800000);
    send_sample(32'd20, 24'hFFFF9C);

    cur_t = 32'd20;
    cur_a = 24'hFFFF9C;
    for (int seg = 0; seg < NumSegments; seg++) begin
      in_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clk);
      case (seg)
        0:       win = 10'd1023;
        1:       win = 10'd0;
        2:       win = 10'd1;
        default: win = WIN_W'($urandom_range(0, 1023));
      endcase
      set_window(win);
      if (seg < 3) begin
        send_idle_pct = 32;
        recv_idle_pct = 82;
      end else if (seg < 6) begin
        send_idle_pct = 82;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      step_max = (int'(win) * 16) / 8 + 2;
      for (int k = 0; k < SegSamples; k++) begin
        if (seg == 6 && k == 40) hold_asked++;
        rt = $urandom_range(0, 99);
        if (rt < 60)      cur_t = cur_t + $urandom_range(1, step_max);
        else if (rt < 70) cur_t = cur_t;
        else if (rt < 78) cur_t = cur_t - $urandom_range(1, step_max);
        else if (rt < 84) cur_t = cur_t + $urandom_range(step_max, 40000);
        else if (rt < 90) cur_t = $urandom();
        else if (rt < 95) cur_t = 32'hFFFF_FFFF - $urandom_range(0, 4000);
        else              cur_t = $urandom_range(0, 4000);
        ra = $urandom_range(0, 99);
        if (ra < 55)      cur_a = cur_a + 24'($urandom_range(0, 4000)) - 24'd2000;
        else if (ra < 70) cur_a = 24'($urandom());
        else if (ra < 78) cur_a = 24'h7FFFFF;
        else if (ra < 86) cur_a = 24'h800000;
        send_sample(cur_t, cur_a);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (120) @(negedge clk);

    $display("Sent %0d sample requests over %0d window writes plus the reset window;",
             n_requests, n_windows);
    $display("checked %0d climb rates, %0d of them from an older sample in window.",
             result_count, found_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout: %0d climb rate results still outstanding", pending_count);
    $display("== FAIL ==");
    $finish;
  end

endmodule
